/* hw/rtl/bmm_pkg.sv */
// Shared types, constants and helpers for the balance robot motor mixer.
`timescale 1ns / 1ps
`default_nettype none

package bmm_pkg;

	// Configuration port geometry
	localparam int unsigned CFG_W = 16;
	localparam int unsigned IDX_W = 3;

	// Configuration register indexes
	typedef enum logic [IDX_W-1:0] {
		REG_TILT_GAIN       = 3'd0,
		REG_TILT_RATE_GAIN  = 3'd1,
		REG_BALANCE_CENTER  = 3'd2,
		REG_SPEED_PROP_GAIN = 3'd3,
		REG_SPEED_INT_GAIN  = 3'd4,
		REG_HEADING_GAIN    = 3'd5,
		REG_TURN_RATE_GAIN  = 3'd6
	} cfg_reg_t;

	// Turn mode codes; the remaining codes hold the last turn term
	typedef enum logic [1:0] {
		TURN_RATE    = 2'd0,
		TURN_HEADING = 2'd1
	} turn_mode_t;

	// Register reset values (gains are unsigned Q8.8)
	localparam logic [15:0]        TILT_GAIN_RST       = 16'd23040;
	localparam logic [15:0]        TILT_RATE_GAIN_RST  = 16'd256;
	localparam logic signed [14:0] BALANCE_CENTER_RST  = -15'sd384;
	localparam logic [15:0]        SPEED_PROP_GAIN_RST = 16'd2560;
	localparam logic [15:0]        SPEED_INT_GAIN_RST  = 16'd256;
	localparam logic [15:0]        HEADING_GAIN_RST    = 16'd2560;
	localparam logic [15:0]        TURN_RATE_GAIN_RST  = 16'd2560;

	// Default tuning of the speed loop
	localparam int unsigned SPEED_DIVIDE_DEF   = 20;
	localparam int unsigned INTEGRAL_LIMIT_DEF = 150;

	// Fixed constants
	localparam int TURN_LIMIT   = 500;
	localparam int FULL_TURN    = 23040;   // 360 deg in 1/64 deg
	localparam int HALF_TURN    = 11520;   // 180 deg in 1/64 deg
	localparam int GYRO_BIAS_X5 = 1056;    // 5 x 3.3 deg/s in 1/64 deg/s
	localparam int DIV5_MAGIC   = 209716;  // ceil(2^20 / 5), exact below 2^18
	localparam int TILT_SAT_MAG = 163840;  // 5 x 32768, |x|/16384 at saturation

	// Pipeline advance and state update strobes from the top level
	typedef struct packed {
		logic adv_s2;
		logic adv_s3;
		logic adv_s4;
		logic upd_s2;
		logic upd_s3;
	} stage_ctl_t;

	// Saturate a 32-bit signed value to 16 bits
	function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
		logic signed [15:0] r;
		if (v > 32'sd32767) begin
			r = 16'sh7FFF;
		end else if (v < -32'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/bmm_tilt.sv */
// Angle PD term: products, truncating divide by 81920, 16-bit saturation.
`timescale 1ns / 1ps
`default_nettype none

module bmm_tilt (
	input  wire logic                clk,
	input  wire bmm_pkg::stage_ctl_t ctl,
	input  wire logic [15:0]         tilt_gain,
	input  wire logic [15:0]         tilt_rate_gain,
	input  wire logic signed [14:0]  balance_center,
	input  wire logic signed [14:0]  angle_s1,
	input  wire logic signed [17:0]  rate_s1,
	output logic signed [15:0]       tilt_s4
);

	logic signed [15:0] diff;
	logic signed [20:0] rate_x;
	logic signed [20:0] rate5;
	logic signed [32:0] prod_a_s2;
	logic signed [37:0] prod_b_s2;

	logic signed [38:0] a_x;
	logic signed [38:0] b_x;
	logic signed [38:0] x_sum;
	logic [38:0]        x_mag;
	logic               neg_s3;
	logic               big_s3;
	logic [17:0]        m_s3;

	logic [35:0]        q_prod;
	logic [14:0]        q_mag;

	// Stage 2: angle error and bias-corrected rate products
	assign diff   = $signed({angle_s1[14], angle_s1}) - $signed({balance_center[14], balance_center});
	assign rate_x = $signed({{3{rate_s1[17]}}, rate_s1});
	assign rate5  = (rate_x <<< 2) + rate_x - 21'(bmm_pkg::GYRO_BIAS_X5);

	always_ff @(posedge clk) begin
		if (ctl.adv_s2) begin
			prod_a_s2 <= diff * $signed({1'b0, tilt_gain});
			prod_b_s2 <= rate5 * $signed({1'b0, tilt_rate_gain});
		end
	end

	// Stage 3: 5*A - B, magnitude scaled by 1/16384, saturation test
	assign a_x   = $signed({{6{prod_a_s2[32]}}, prod_a_s2});
	assign b_x   = $signed({prod_b_s2[37], prod_b_s2});
	assign x_sum = (a_x <<< 2) + a_x - b_x;
	assign x_mag = x_sum[38] ? 39'(-x_sum) : 39'(x_sum);

	always_ff @(posedge clk) begin
		if (ctl.adv_s3) begin
			neg_s3 <= x_sum[38];
			big_s3 <= (x_mag[37:14] >= 24'(bmm_pkg::TILT_SAT_MAG));
			m_s3   <= x_mag[31:14];
		end
	end

	// Stage 4: divide by 5 through the reciprocal, then apply sign
	assign q_prod = m_s3 * 18'(bmm_pkg::DIV5_MAGIC);
	assign q_mag  = q_prod[34:20];

	always_ff @(posedge clk) begin
		if (ctl.adv_s4) begin
			if (big_s3) begin
				tilt_s4 <= neg_s3 ? 16'sh8000 : 16'sh7FFF;
			end else if (neg_s3) begin
				tilt_s4 <= -$signed({1'b0, q_mag});
			end else begin
				tilt_s4 <= $signed({1'b0, q_mag});
			end
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/bmm_turn.sv */
// Turn term: rate or heading mode, clamp to +-500, held between updates.
`timescale 1ns / 1ps
`default_nettype none

module bmm_turn (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire bmm_pkg::stage_ctl_t ctl,
	input  wire logic [15:0]         heading_gain,
	input  wire logic [15:0]         turn_rate_gain,
	input  wire logic signed [15:0]  yaw_s1,
	input  wire logic signed [15:0]  head_s1,
	input  wire logic [1:0]          mode_s1,
	input  wire logic signed [10:0]  trate_s1,
	output logic signed [9:0]        turn_s3
);

	localparam logic signed [16:0] FULL_P = 17'(bmm_pkg::FULL_TURN);
	localparam logic signed [16:0] HALF_P = 17'(bmm_pkg::HALF_TURN);
	localparam logic signed [31:0] LIM_P  = 32'(bmm_pkg::TURN_LIMIT);

	logic signed [16:0] err;
	logic signed [16:0] err_wrap;
	logic               wrap_ok;
	logic [15:0]        gain_sel;
	logic signed [14:0] opnd_sel;
	logic               hd_sel;
	logic               load_sel;

	logic [15:0]        gain_s2;
	logic signed [14:0] opnd_s2;
	logic               hd_s2;
	logic               load_s2;

	logic signed [31:0] prod;
	logic signed [31:0] quot;
	logic signed [9:0]  turn_new;
	logic signed [9:0]  held_turn_q;

	// Heading error wrapped once into [-180, 180) degrees
	assign err = $signed({yaw_s1[15], yaw_s1}) - $signed({head_s1[15], head_s1});

	always_comb begin
		err_wrap = err;
		wrap_ok  = 1'b1;
		if (err >= -FULL_P && err < -HALF_P) begin
			err_wrap = err + FULL_P;
		end else if (err >= -HALF_P && err < HALF_P) begin
			err_wrap = err;
		end else if (err >= HALF_P && err <= FULL_P) begin
			err_wrap = err - FULL_P;
		end else begin
			wrap_ok = 1'b0;
		end
	end

	// Operand and gain select for the shared multiplier
	always_comb begin
		gain_sel = turn_rate_gain;
		opnd_sel = $signed({{4{trate_s1[10]}}, trate_s1});
		hd_sel   = 1'b0;
		load_sel = 1'b0;
		case (bmm_pkg::turn_mode_t'(mode_s1))
			bmm_pkg::TURN_RATE: begin
				load_sel = 1'b1;
			end
			bmm_pkg::TURN_HEADING: begin
				gain_sel = heading_gain;
				opnd_sel = err_wrap[14:0];
				hd_sel   = 1'b1;
				load_sel = wrap_ok;
			end
			default: begin
				load_sel = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.adv_s2) begin
			gain_s2 <= gain_sel;
			opnd_s2 <= opnd_sel;
			hd_s2   <= hd_sel;
			load_s2 <= load_sel;
		end
	end

	// Stage 3: product, truncate toward zero, clamp
	assign prod = opnd_s2 * $signed({1'b0, gain_s2});

	always_comb begin
		if (hd_s2) begin
			quot = (prod + (prod[31] ? 32'sd16383 : 32'sd0)) >>> 14;
		end else begin
			quot = (prod + (prod[31] ? 32'sd255 : 32'sd0)) >>> 8;
		end
		if (quot > LIM_P) begin
			turn_new = LIM_P[9:0];
		end else if (quot < -LIM_P) begin
			turn_new = 10'(-LIM_P);
		end else begin
			turn_new = quot[9:0];
		end
	end

	// Held turn term
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_turn_q <= '0;
		end else if (ctl.upd_s3 && load_s2) begin
			held_turn_q <= turn_new;
		end
	end

	assign turn_s3 = held_turn_q;

endmodule

`default_nettype wire

/* hw/rtl/bmm_speed.sv */
// Speed PI term: decimation counter, clamped integral, held output.
`timescale 1ns / 1ps
`default_nettype none

module bmm_speed #(
	parameter int unsigned SPEED_DIVIDE   = bmm_pkg::SPEED_DIVIDE_DEF,
	parameter int unsigned INTEGRAL_LIMIT = bmm_pkg::INTEGRAL_LIMIT_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire bmm_pkg::stage_ctl_t ctl,
	input  wire logic [15:0]         speed_prop_gain,
	input  wire logic [15:0]         speed_int_gain,
	input  wire logic signed [8:0]   starget_s1,
	input  wire logic signed [12:0]  wsum_s1,
	output logic signed [15:0]       speed_s3
);

	localparam int unsigned CNT_W = $clog2(SPEED_DIVIDE + 1);
	localparam int unsigned IW    = $clog2(INTEGRAL_LIMIT + 1) + 1;
	localparam logic signed [14:0] LIM_P = 15'(INTEGRAL_LIMIT);

	logic [CNT_W-1:0]        count_q;
	logic [CNT_W-1:0]        count_inc;
	logic                    tick;
	logic signed [IW-1:0]    integral_q;
	logic signed [13:0]      perr;
	logic signed [14:0]      isum;
	logic signed [IW-1:0]    integral_new;

	logic signed [13:0]      perr_s2;
	logic signed [IW-1:0]    integ_s2;
	logic                    tick_s2;

	logic signed [31:0]      prod_p;
	logic signed [31:0]      prod_i;
	logic signed [31:0]      psum;
	logic signed [31:0]      quot;
	logic signed [15:0]      held_speed_q;

	// Stage 2: speed error and integral with clamp
	assign perr      = $signed({{5{starget_s1[8]}}, starget_s1}) - $signed({wsum_s1[12], wsum_s1});
	assign count_inc = count_q + 1'b1;
	assign tick      = (count_inc >= CNT_W'(SPEED_DIVIDE));
	assign isum      = $signed({{(15-IW){integral_q[IW-1]}}, integral_q}) + $signed({perr[13], perr});

	always_comb begin
		if (isum > LIM_P) begin
			integral_new = LIM_P[IW-1:0];
		end else if (isum < -LIM_P) begin
			integral_new = IW'(-LIM_P);
		end else begin
			integral_new = isum[IW-1:0];
		end
	end

	// Decimation counter and integral state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			integral_q <= '0;
		end else if (ctl.upd_s2) begin
			if (tick) begin
				count_q    <= '0;
				integral_q <= integral_new;
			end else begin
				count_q <= count_inc;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv_s2) begin
			perr_s2  <= perr;
			integ_s2 <= integral_new;
			tick_s2  <= tick;
		end
	end

	// Stage 3: PI products, truncate toward zero, saturate
	assign prod_p = perr_s2 * $signed({1'b0, speed_prop_gain});
	assign prod_i = integ_s2 * $signed({1'b0, speed_int_gain});
	assign psum   = prod_p + prod_i;
	assign quot   = (psum + (psum[31] ? 32'sd255 : 32'sd0)) >>> 8;

	// Held speed term
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_speed_q <= '0;
		end else if (ctl.upd_s3 && tick_s2) begin
			held_speed_q <= bmm_pkg::sat16(quot);
		end
	end

	assign speed_s3 = held_speed_q;

endmodule

`default_nettype wire

/* hw/rtl/balance_robot_motor_mixer.sv */
// Top level of the two-wheel balance robot motor mixer.
//
// One input transaction carries one control tick: tilt angle, pitch rate,
// heading, turn command, speed command and wheel speed sum, plus the
// running flag. Each tick yields one output transaction with both motor
// drives and the tilt, speed and turn terms.
// Channels use valid/ready; a new tick is taken every cycle while in_ready is
// high, and an accepted tick passes in order through a 5-stage pipeline (input
// register, products, sums, divide/turn/speed hold, output mix) to the result register.
// When the receiver stalls the pipeline fills; in_ready drops only while
// a finished result waits in the output register and every stage is full.
// Bubbles are squeezed out as items move forward.
// Configuration registers are written through cfg_we/cfg_index/cfg_data
// with no wait; write them only while no tick is in flight.
// Reset clears the pipeline, the decimation counter, the speed integral
// and the held speed and turn terms, and loads the register defaults.
// A stopped tick (running low) gives all-zero outputs and changes no state.
`timescale 1ns / 1ps
`default_nettype none

module balance_robot_motor_mixer #(
	parameter int unsigned SPEED_DIVIDE   = bmm_pkg::SPEED_DIVIDE_DEF,
	parameter int unsigned INTEGRAL_LIMIT = bmm_pkg::INTEGRAL_LIMIT_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	// configuration write port
	input  wire logic                      cfg_we,
	input  wire logic [bmm_pkg::IDX_W-1:0] cfg_index,
	input  wire logic [bmm_pkg::CFG_W-1:0] cfg_data,
	// input channel
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic                      running,
	input  wire logic signed [14:0]        tilt_angle,
	input  wire logic signed [17:0]        tilt_rate,
	input  wire logic signed [15:0]        yaw_angle,
	input  wire logic signed [15:0]        heading_target,
	input  wire logic [1:0]                turn_mode,
	input  wire logic signed [10:0]        turn_rate_target,
	input  wire logic signed [8:0]         speed_cmd,
	input  wire logic signed [12:0]        wheel_speed_sum,
	// output channel
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic signed [15:0]             left_drive,
	output logic signed [15:0]             right_drive,
	output logic signed [15:0]             tilt_term,
	output logic signed [15:0]             speed_term,
	output logic signed [9:0]              turn_term
);

	// Configuration registers
	logic [15:0]        tilt_gain_q;
	logic [15:0]        tilt_rate_gain_q;
	logic signed [14:0] balance_center_q;
	logic [15:0]        speed_prop_gain_q;
	logic [15:0]        speed_int_gain_q;
	logic [15:0]        heading_gain_q;
	logic [15:0]        turn_rate_gain_q;

	// Pipeline valids and running flags
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic run_s1, run_s2, run_s3, run_s4;
	logic adv_s1, adv_s2, adv_s3, adv_s4, adv_s5;
	bmm_pkg::stage_ctl_t ctl;

	// Input register payload
	logic signed [14:0] angle_s1;
	logic signed [17:0] rate_s1;
	logic signed [15:0] yaw_s1;
	logic signed [15:0] head_s1;
	logic [1:0]         mode_s1;
	logic signed [10:0] trate_s1;
	logic signed [8:0]  starget_s1;
	logic signed [12:0] wsum_s1;

	// Term values
	logic signed [15:0] tilt_s4;
	logic signed [9:0]  turn_s3;
	logic signed [15:0] speed_s3;
	logic signed [9:0]  turn_s4;
	logic signed [15:0] speed_s4;

	// Output mix
	logic signed [31:0] base_sum;
	logic signed [31:0] left_sum;
	logic signed [31:0] right_sum;

	logic signed [15:0] left_s5;
	logic signed [15:0] right_s5;
	logic signed [15:0] tilt_s5;
	logic signed [15:0] speed_s5;
	logic signed [9:0]  turn_s5;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tilt_gain_q       <= bmm_pkg::TILT_GAIN_RST;
			tilt_rate_gain_q  <= bmm_pkg::TILT_RATE_GAIN_RST;
			balance_center_q  <= bmm_pkg::BALANCE_CENTER_RST;
			speed_prop_gain_q <= bmm_pkg::SPEED_PROP_GAIN_RST;
			speed_int_gain_q  <= bmm_pkg::SPEED_INT_GAIN_RST;
			heading_gain_q    <= bmm_pkg::HEADING_GAIN_RST;
			turn_rate_gain_q  <= bmm_pkg::TURN_RATE_GAIN_RST;
		end else if (cfg_we) begin
			case (bmm_pkg::cfg_reg_t'(cfg_index))
				bmm_pkg::REG_TILT_GAIN:       tilt_gain_q       <= cfg_data;
				bmm_pkg::REG_TILT_RATE_GAIN:  tilt_rate_gain_q  <= cfg_data;
				bmm_pkg::REG_BALANCE_CENTER:  balance_center_q  <= cfg_data[14:0];
				bmm_pkg::REG_SPEED_PROP_GAIN: speed_prop_gain_q <= cfg_data;
				bmm_pkg::REG_SPEED_INT_GAIN:  speed_int_gain_q  <= cfg_data;
				bmm_pkg::REG_HEADING_GAIN:    heading_gain_q    <= cfg_data;
				bmm_pkg::REG_TURN_RATE_GAIN:  turn_rate_gain_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Stage advance: a stage moves when it is empty or the next one moves
	assign adv_s5 = !v_s5 || out_ready;
	assign adv_s4 = !v_s4 || adv_s5;
	assign adv_s3 = !v_s3 || adv_s4;
	assign adv_s2 = !v_s2 || adv_s3;
	assign adv_s1 = !v_s1 || adv_s2;
	assign in_ready = adv_s1;

	assign ctl.adv_s2 = adv_s2;
	assign ctl.adv_s3 = adv_s3;
	assign ctl.adv_s4 = adv_s4;
	assign ctl.upd_s2 = adv_s2 && v_s1 && run_s1;
	assign ctl.upd_s3 = adv_s3 && v_s2 && run_s2;

	// Valid and running flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			v_s5   <= 1'b0;
			run_s1 <= 1'b0;
			run_s2 <= 1'b0;
			run_s3 <= 1'b0;
			run_s4 <= 1'b0;
		end else begin
			if (adv_s1) begin
				v_s1   <= in_valid;
				run_s1 <= running;
			end
			if (adv_s2) begin
				v_s2   <= v_s1;
				run_s2 <= run_s1;
			end
			if (adv_s3) begin
				v_s3   <= v_s2;
				run_s3 <= run_s2;
			end
			if (adv_s4) begin
				v_s4   <= v_s3;
				run_s4 <= run_s3;
			end
			if (adv_s5) begin
				v_s5 <= v_s4;
			end
		end
	end

	// Input register
	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			angle_s1   <= tilt_angle;
			rate_s1    <= tilt_rate;
			yaw_s1     <= yaw_angle;
			head_s1    <= heading_target;
			mode_s1    <= turn_mode;
			trate_s1   <= turn_rate_target;
			starget_s1 <= speed_cmd;
			wsum_s1    <= wheel_speed_sum;
		end
	end

	bmm_tilt u_tilt (
		.clk            (clk),
		.ctl            (ctl),
		.tilt_gain      (tilt_gain_q),
		.tilt_rate_gain (tilt_rate_gain_q),
		.balance_center (balance_center_q),
		.angle_s1       (angle_s1),
		.rate_s1        (rate_s1),
		.tilt_s4        (tilt_s4)
	);

	bmm_turn u_turn (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctl            (ctl),
		.heading_gain   (heading_gain_q),
		.turn_rate_gain (turn_rate_gain_q),
		.yaw_s1         (yaw_s1),
		.head_s1        (head_s1),
		.mode_s1        (mode_s1),
		.trate_s1       (trate_s1),
		.turn_s3        (turn_s3)
	);

	bmm_speed #(
		.SPEED_DIVIDE   (SPEED_DIVIDE),
		.INTEGRAL_LIMIT (INTEGRAL_LIMIT)
	) u_speed (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctl             (ctl),
		.speed_prop_gain (speed_prop_gain_q),
		.speed_int_gain  (speed_int_gain_q),
		.starget_s1      (starget_s1),
		.wsum_s1         (wsum_s1),
		.speed_s3        (speed_s3)
	);

	// Align turn and speed with the tilt divide stage
	always_ff @(posedge clk) begin
		if (adv_s4) begin
			turn_s4  <= turn_s3;
			speed_s4 <= speed_s3;
		end
	end

	// Output mix: tilt - speed +/- turn, saturated
	assign base_sum  = $signed({{16{tilt_s4[15]}}, tilt_s4}) - $signed({{16{speed_s4[15]}}, speed_s4});
	assign left_sum  = base_sum + $signed({{22{turn_s4[9]}}, turn_s4});
	assign right_sum = base_sum - $signed({{22{turn_s4[9]}}, turn_s4});

	always_ff @(posedge clk) begin
		if (adv_s5) begin
			if (run_s4) begin
				left_s5  <= bmm_pkg::sat16(left_sum);
				right_s5 <= bmm_pkg::sat16(right_sum);
				tilt_s5  <= tilt_s4;
				speed_s5 <= speed_s4;
				turn_s5  <= turn_s4;
			end else begin
				left_s5  <= '0;
				right_s5 <= '0;
				tilt_s5  <= '0;
				speed_s5 <= '0;
				turn_s5  <= '0;
			end
		end
	end

	assign out_valid   = v_s5;
	assign left_drive  = left_s5;
	assign right_drive = right_s5;
	assign tilt_term   = tilt_s5;
	assign speed_term  = speed_s5;
	assign turn_term   = turn_s5;

endmodule

`default_nettype wire

/* hw/rtl/bmm_checker.sv */
// Port-level checker for the motor mixer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module bmm_checker (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      in_valid,
	input wire logic                      in_ready,
	input wire logic                      out_valid,
	input wire logic                      out_ready,
	input wire logic signed [15:0]        left_drive,
	input wire logic signed [15:0]        right_drive,
	input wire logic signed [9:0]         turn_term
);

	logic drives_unsat;
	logic signed [16:0] drive_diff;
	logic signed [16:0] turn_x2;

	assign drives_unsat = left_drive != 16'sh7FFF && left_drive != 16'sh8000 &&
	                      right_drive != 16'sh7FFF && right_drive != 16'sh8000;
	assign drive_diff   = $signed({left_drive[15], left_drive}) - $signed({right_drive[15], right_drive});
	assign turn_x2      = $signed({{6{turn_term[9]}}, turn_term, 1'b0});

	// A stalled result transaction holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(left_drive) && $stable(right_drive) &&
		$stable(turn_term))
		else $error("output transaction changed while stalled");

	// Input backpressure only comes from a stalled full output register
	a_ready_source: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && !out_ready)
		else $error("in_ready low without an output stall");

	// Turn term always inside the clamp
	a_turn_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> turn_term <= 10'sd500 && turn_term >= -10'sd500)
		else $error("turn term outside +-500");

	// Unsaturated drives differ by exactly twice the turn term
	a_drive_split: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && drives_unsat |-> drive_diff == turn_x2)
		else $error("left/right drives do not split by the turn term");

	// in_take marks an accepted input transaction: in_valid and in_ready both high
	logic in_take;
	assign in_take = in_valid && in_ready;

	a_in_take: assert property (@(posedge clk) disable iff (!arst_n)
		in_take |-> in_ready)
		else $error("input transaction accepted without ready");

endmodule

bind balance_robot_motor_mixer bmm_checker u_bmm_checker (.*);

`default_nettype wire

/* verif/balance_robot_motor_mixer_tb.sv */
// Self-checking testbench for the balance robot motor mixer: random stalls, gain sweeps.
`timescale 1ns / 1ps

module balance_robot_motor_mixer_tb;

	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASES      = 8;
	localparam int PHASE_TICKS = 200;

	// Predictor constants
	localparam longint TILT_DIV    = 81920;
	localparam longint BIAS_X5     = 1056;   // gyro bias x5 in 1/64 deg/s
	localparam longint DEG360      = 23040;
	localparam longint DEG180      = 11520;
	localparam longint TURN_CLAMP  = 500;
	localparam longint INTEG_CLAMP = 150;
	localparam int     SPEED_EVERY = 20;

	// Turn codes outside the enum both hold the last turn term
	localparam logic [1:0] TURN_HOLD     = 2'd2;
	localparam logic [1:0] TURN_HOLD_ALT = 2'd3;

	typedef struct packed {
		logic               running;
		logic signed [14:0] tilt_angle;
		logic signed [17:0] tilt_rate;
		logic signed [15:0] yaw_angle;
		logic signed [15:0] heading_target;
		logic [1:0]         turn_mode;
		logic signed [10:0] turn_rate_target;
		logic signed [8:0]  speed_cmd;
		logic signed [12:0] wheel_speed_sum;
	} tick_t;

	typedef struct packed {
		logic signed [15:0] left_drv;
		logic signed [15:0] right_drv;
		logic signed [15:0] tilt_val;
		logic signed [15:0] speed_val;
		logic signed [9:0]  turn_val;
	} mix_t;

	// DUT connections, all inputs known from time zero
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [bmm_pkg::IDX_W-1:0] cfg_index = '0;
	logic [bmm_pkg::CFG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic running = 1'b0;
	logic signed [14:0] tilt_angle = '0;
	logic signed [17:0] tilt_rate = '0;
	logic signed [15:0] yaw_angle = '0;
	logic signed [15:0] heading_target = '0;
	logic [1:0] turn_mode = '0;
	logic signed [10:0] turn_rate_target = '0;
	logic signed [8:0] speed_cmd = '0;
	logic signed [12:0] wheel_speed_sum = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [15:0] left_drive;
	logic signed [15:0] right_drive;
	logic signed [15:0] tilt_term;
	logic signed [15:0] speed_term;
	logic signed [9:0] turn_term;

	// Predictor copy of the gain registers and loop state
	logic [15:0] g_tilt = 16'd23040;
	logic [15:0] g_tilt_rate = 16'd256;
	logic signed [14:0] g_center = -15'sd384;
	logic [15:0] g_speed_p = 16'd2560;
	logic [15:0] g_speed_i = 16'd256;
	logic [15:0] g_heading = 16'd2560;
	logic [15:0] g_turn_rate = 16'd2560;
	logic [7:0] speed_tick_cnt = '0;
	longint speed_acc = 0;
	longint speed_hold = 0;
	longint turn_hold = 0;

	tick_t tick_q[$];
	mix_t drive_exp_q[$];
	int idle_pct = 35;
	int fail_cnt = 0;
	int ticks_taken = 0;
	int results_seen = 0;
	int stopped_ticks = 0;
	int cycle_cnt = 0;
	logic tick_taken = 1'b0;

	balance_robot_motor_mixer uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.running         (running),
		.tilt_angle      (tilt_angle),
		.tilt_rate       (tilt_rate),
		.yaw_angle       (yaw_angle),
		.heading_target  (heading_target),
		.turn_mode       (turn_mode),
		.turn_rate_target(turn_rate_target),
		.speed_cmd       (speed_cmd),
		.wheel_speed_sum (wheel_speed_sum),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.left_drive      (left_drive),
		.right_drive     (right_drive),
		.tilt_term       (tilt_term),
		.speed_term      (speed_term),
		.turn_term       (turn_term)
	);

	always #2 clk = ~clk;

	always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

	function automatic longint clip(input longint v, input longint lo, input longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	// One control tick: PD tilt, held/updated turn, decimated speed PI, mix
	function automatic mix_t mix_tick(input tick_t t);
		mix_t r;
		longint ang, rate, yaw, hdg, trt, st, ws;
		longint tilt_l, err, diff;
		logic aim_ok;
		r = '0;
		ang = t.tilt_angle;
		rate = t.tilt_rate;
		yaw = t.yaw_angle;
		hdg = t.heading_target;
		trt = t.turn_rate_target;
		st = t.speed_cmd;
		ws = t.wheel_speed_sum;
		if (t.running) begin
			tilt_l = 5 * longint'(g_tilt) * (ang - longint'(g_center))
				- longint'(g_tilt_rate) * (5 * rate - BIAS_X5);
			tilt_l = clip(tilt_l / TILT_DIV, -32768, 32767);

			// turn term; hold codes and errors past a full turn keep the old value
			if (t.turn_mode == bmm_pkg::TURN_RATE) begin
				turn_hold = clip(longint'(g_turn_rate) * trt / 256, -TURN_CLAMP, TURN_CLAMP);
			end else if (t.turn_mode == bmm_pkg::TURN_HEADING) begin
				err = yaw - hdg;
				aim_ok = 1'b1;
				if (err >= -DEG360 && err < -DEG180) begin
					err = err + DEG360;
				end else if (err >= DEG180 && err <= DEG360) begin
					err = err - DEG360;
				end else if (err < -DEG180 || err >= DEG180) begin
					aim_ok = 1'b0;
				end
				if (aim_ok) begin
					turn_hold = clip(longint'(g_heading) * err / 16384, -TURN_CLAMP, TURN_CLAMP);
				end
			end

			// speed PI on every SPEED_EVERY-th running tick
			speed_tick_cnt = speed_tick_cnt + 8'd1;
			if (speed_tick_cnt >= SPEED_EVERY) begin
				speed_tick_cnt = '0;
				diff = st - ws;
				speed_acc = clip(speed_acc + diff, -INTEG_CLAMP, INTEG_CLAMP);
				speed_hold = clip((diff * longint'(g_speed_p) + speed_acc * longint'(g_speed_i))
					/ 256, -32768, 32767);
			end

			r.left_drv = 16'(clip(tilt_l - speed_hold + turn_hold, -32768, 32767));
			r.right_drv = 16'(clip(tilt_l - speed_hold - turn_hold, -32768, 32767));
			r.tilt_val = 16'(tilt_l);
			r.speed_val = 16'(speed_hold);
			r.turn_val = 10'(turn_hold);
		end
		return r;
	endfunction

	function automatic tick_t mk_tick(input int run, input int ang, input int rate, input int yaw,
			input int hdg, input logic [1:0] mode, input int trt, input int st, input int ws);
		tick_t t;
		t.running = run[0];
		t.tilt_angle = 15'(ang);
		t.tilt_rate = 18'(rate);
		t.yaw_angle = 16'(yaw);
		t.heading_target = 16'(hdg);
		t.turn_mode = mode;
		t.turn_rate_target = 11'(trt);
		t.speed_cmd = 9'(st);
		t.wheel_speed_sum = 13'(ws);
		return t;
	endfunction

	// Mostly in-range ticks, some full-width, some near the balance point
	function automatic tick_t rand_tick();
		tick_t t;
		int pick;
		int off;
		t.running = ($urandom_range(99) < 92);
		pick = $urandom_range(9);
		if (pick < 2) t.tilt_angle = 15'($urandom);
		else if (pick < 4) t.tilt_angle = 15'(int'($urandom_range(600)) - 684);
		else t.tilt_angle = 15'(int'($urandom_range(23040)) - 11520);
		pick = $urandom_range(9);
		if (pick < 2) t.tilt_rate = 18'($urandom);
		else if (pick < 4) t.tilt_rate = 18'(int'($urandom_range(800)) - 189);
		else t.tilt_rate = 18'(int'($urandom_range(256000)) - 128000);
		if ($urandom_range(4) == 0) begin
			t.yaw_angle = 16'($urandom);
			t.heading_target = 16'($urandom);
		end else begin
			t.yaw_angle = 16'(int'($urandom_range(46080)) - 23040);
			t.heading_target = 16'(int'($urandom_range(46080)) - 23040);
		end
		// heading errors right at the wrap and hold boundaries
		if ($urandom_range(7) == 0) begin
			case ($urandom_range(7))
				0: off = -23041;
				1: off = -23040;
				2: off = -11521;
				3: off = -11520;
				4: off = 11519;
				5: off = 11520;
				6: off = 23040;
				default: off = 23041;
			endcase
			t.heading_target = 16'(int'(t.yaw_angle) - off);
		end
		pick = $urandom_range(9);
		if (pick < 4) t.turn_mode = bmm_pkg::TURN_RATE;
		else if (pick < 8) t.turn_mode = bmm_pkg::TURN_HEADING;
		else t.turn_mode = ($urandom_range(1) == 0) ? TURN_HOLD : TURN_HOLD_ALT;
		t.turn_rate_target = 11'($urandom);
		t.speed_cmd = 9'($urandom);
		if ($urandom_range(1) == 0) t.wheel_speed_sum = 13'($urandom);
		else t.wheel_speed_sum = 13'(int'($urandom_range(600)) - 300);
		return t;
	endfunction

	task automatic check_field(input string name, input longint want, input longint got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_cnt++;
		end
	endtask

	// Driver: next tick goes out at the falling edge once the last one was taken
	always @(negedge clk) begin : drive_ticks
		tick_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || tick_taken) begin
			if (tick_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
				nxt = tick_q.pop_front();
				in_valid <= 1'b1;
				running <= nxt.running;
				tilt_angle <= nxt.tilt_angle;
				tilt_rate <= nxt.tilt_rate;
				yaw_angle <= nxt.yaw_angle;
				heading_target <= nxt.heading_target;
				turn_mode <= nxt.turn_mode;
				turn_rate_target <= nxt.turn_rate_target;
				speed_cmd <= nxt.speed_cmd;
				wheel_speed_sum <= nxt.wheel_speed_sum;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Result side back-pressure
	always @(negedge clk) begin
		out_ready <= arst_n && ($urandom_range(99) >= idle_pct);
	end

	// Monitor: register writes, result checks, then prediction of the new transaction
	always @(posedge clk) begin : watch_mixer
		mix_t want;
		tick_t seen;
		if (arst_n) begin
			if (cfg_we) begin
				case (bmm_pkg::cfg_reg_t'(cfg_index))
					bmm_pkg::REG_TILT_GAIN:       g_tilt = cfg_data;
					bmm_pkg::REG_TILT_RATE_GAIN:  g_tilt_rate = cfg_data;
					bmm_pkg::REG_BALANCE_CENTER:  g_center = cfg_data[14:0];
					bmm_pkg::REG_SPEED_PROP_GAIN: g_speed_p = cfg_data;
					bmm_pkg::REG_SPEED_INT_GAIN:  g_speed_i = cfg_data;
					bmm_pkg::REG_HEADING_GAIN:    g_heading = cfg_data;
					bmm_pkg::REG_TURN_RATE_GAIN:  g_turn_rate = cfg_data;
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (drive_exp_q.size() == 0) begin
					$error("result with no tick outstanding: left_drive %0d", left_drive);
					fail_cnt++;
				end else begin
					want = drive_exp_q.pop_front();
					check_field("left_drive", want.left_drv, left_drive);
					check_field("right_drive", want.right_drv, right_drive);
					check_field("tilt_term", want.tilt_val, tilt_term);
					check_field("speed_term", want.speed_val, speed_term);
					check_field("turn_term", want.turn_val, turn_term);
				end
				results_seen <= results_seen + 1;
			end
			if (in_valid && in_ready) begin
				seen = '{running, tilt_angle, tilt_rate, yaw_angle, heading_target, turn_mode,
					turn_rate_target, speed_cmd, wheel_speed_sum};
				drive_exp_q.push_back(mix_tick(seen));
				ticks_taken <= ticks_taken + 1;
				stopped_ticks <= stopped_ticks + (running ? 0 : 1);
			end
			tick_taken <= in_valid && in_ready;
		end
	end

	// Returns at a rising edge with nothing queued, driven or outstanding
	task automatic wait_idle();
		do @(posedge clk);
		while (tick_q.size() != 0 || in_valid || ticks_taken != results_seen);
	endtask

	task automatic write_reg(input bmm_pkg::cfg_reg_t idx, input logic [15:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
	endtask

	task automatic set_gains(input logic [15:0] tg, input logic [15:0] trg, input logic [15:0] bc,
			input logic [15:0] spg, input logic [15:0] sig, input logic [15:0] hg,
			input logic [15:0] rg);
		write_reg(bmm_pkg::REG_TILT_GAIN, tg);
		write_reg(bmm_pkg::REG_TILT_RATE_GAIN, trg);
		write_reg(bmm_pkg::REG_BALANCE_CENTER, bc);
		write_reg(bmm_pkg::REG_SPEED_PROP_GAIN, spg);
		write_reg(bmm_pkg::REG_SPEED_INT_GAIN, sig);
		write_reg(bmm_pkg::REG_HEADING_GAIN, hg);
		write_reg(bmm_pkg::REG_TURN_RATE_GAIN, rg);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_gains(input int hi, input bit wide_center);
		logic [15:0] bc;
		bc = wide_center ? 16'($urandom) : 16'(int'($urandom_range(23040)) - 11520);
		set_gains(16'($urandom_range(hi)), 16'($urandom_range(hi)), bc,
			16'($urandom_range(hi)), 16'($urandom_range(hi)), 16'($urandom_range(hi)),
			16'($urandom_range(hi)));
	endtask

	task automatic queue_random(input int n);
		repeat (n) tick_q.push_back(rand_tick());
	endtask

	// Timeout guard
	initial begin
		wait (cycle_cnt >= CYCLE_LIMIT);
		$display("Some tests failed");
		$finish;
	end

	// Stimulus and end of run
	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		for (int ph = 0; ph < PHASES; ph++) begin
			wait_idle();
			repeat (6) @(negedge clk);
			case (ph)
				1: set_gains(16'hFFFF, 16'hFFFF, 16'h3FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
				2: set_gains(16'h0000, 16'h0000, 16'h4000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
				3: random_gains(65535, 1'b0);
				4: set_gains(16'd23040, 16'd256, -16'sd384, 16'd2560, 16'd256, 16'd2560, 16'd2560);
				5: random_gains(1024, 1'b1);
				6: random_gains(65535, 1'b0);
				7: random_gains(8192, 1'b0);
				default: ;
			endcase
			@(posedge clk);
			// one phase runs with both sides always ready
			idle_pct = (ph == 3) ? 0 : 35;
			if (ph == 0) begin
				tick_q.push_back(mk_tick(1, 0, 0, 0, 0, bmm_pkg::TURN_RATE, 0, 0, 0));
				tick_q.push_back(mk_tick(1, 16383, -131072, 0, 0, bmm_pkg::TURN_RATE,
					1023, 255, -4096));
				tick_q.push_back(mk_tick(1, -16384, 131071, 0, 0, bmm_pkg::TURN_RATE,
					-1024, -256, 4095));
				// stopped tick with every field at an extreme
				tick_q.push_back(mk_tick(0, 16383, 131071, 32767, -32768, bmm_pkg::TURN_HEADING,
					1023, 255, 4095));
				// heading error across both wrap points
				tick_q.push_back(mk_tick(1, -384, 211, -23040, 0, bmm_pkg::TURN_HEADING, 0, 0, 0));
				tick_q.push_back(mk_tick(1, 0, 0, -11521, 0, bmm_pkg::TURN_HEADING, 0, 0, 0));
				tick_q.push_back(mk_tick(1, 0, 0, -11520, 0, bmm_pkg::TURN_HEADING, 0, 0, 0));
				tick_q.push_back(mk_tick(1, 0, 0, 11519, 0, bmm_pkg::TURN_HEADING, 0, 0, 0));
				tick_q.push_back(mk_tick(1, 0, 0, 11520, 0, bmm_pkg::TURN_HEADING, 0, 0, 0));
				tick_q.push_back(mk_tick(1, 0, 0, 23040, 0, bmm_pkg::TURN_HEADING, 0, 0, 0));
				tick_q.push_back(mk_tick(1, 0, 0, 0, -5000, bmm_pkg::TURN_HEADING, 0, 0, 0));
				// errors past a full turn keep the last turn term
				tick_q.push_back(mk_tick(1, 0, 0, 23041, 0, bmm_pkg::TURN_HEADING, 0, 0, 0));
				tick_q.push_back(mk_tick(1, 0, 0, -23041, 0, bmm_pkg::TURN_HEADING, 0, 0, 0));
				tick_q.push_back(mk_tick(1, 0, 0, 32767, -32768, bmm_pkg::TURN_HEADING, 0, 0, 0));
				tick_q.push_back(mk_tick(1, 100, -50, 0, 0, TURN_HOLD, 1023, 0, 0));
				tick_q.push_back(mk_tick(1, -100, 50, 0, 0, TURN_HOLD_ALT, -1024, 0, 0));
				tick_q.push_back(mk_tick(1, 11520, -128000, 23040, -23040, bmm_pkg::TURN_RATE,
					511, -255, 4095));
				tick_q.push_back(mk_tick(1, -11520, 128000, -23040, 23040, bmm_pkg::TURN_HEADING,
					-512, 255, -4096));
				tick_q.push_back(mk_tick(0, 0, 0, 0, 0, bmm_pkg::TURN_RATE, 0, 0, 0));
				tick_q.push_back(mk_tick(1, 5, -5, 100, 100, bmm_pkg::TURN_HEADING, 0, 0, 0));
				// nineteenth running tick; the next running tick is the first speed loop update
				tick_q.push_back(mk_tick(1, -384, 211, 0, 0, bmm_pkg::TURN_RATE, -1, 255, -4096));
				queue_random(PHASE_TICKS - 21);
			end else if (ph == 7) begin
				// sender holds off mid-phase until the pipeline has fully drained
				queue_random(PHASE_TICKS / 2);
				wait_idle();
				queue_random(PHASE_TICKS / 2);
			end else begin
				queue_random(PHASE_TICKS);
			end
		end
		wait_idle();
		repeat (8) @(posedge clk);
		@(negedge clk);
		if (drive_exp_q.size() != 0) begin
			$error("%0d expected results never arrived", drive_exp_q.size());
		end
		$display("Checked %0d results for %0d ticks (%0d stopped) over %0d gain settings.",
			results_seen, ticks_taken, stopped_ticks, PHASES);
		$display("Covered heading wrap and hold, turn holds, saturation and stall gaps.");
		if (fail_cnt == 0 && drive_exp_q.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
